[hdl/nas_pkg.sv]
`default_nettype none
package nas_pkg;

  localparam int MAX_ROW_POINTS = 1024;
  localparam int ADDR_W = $clog2(MAX_ROW_POINTS);
  localparam int ROW_MIN = 2;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic REG_TIME_STEP  = 1'b0;
  localparam logic REG_ROW_POINTS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_SUM,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_MASS,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_T4,
    OP_XLO,
    OP_XHI,
    OP_YLO,
    OP_YHI
  } mul_op_t;

  typedef struct packed {
    logic    accept;
    logic    mul_go;
    logic    wb;
    mul_op_t op;
    logic    pass;
    logic    sum;
    logic    div_step;
    logic    upd;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic interior;
    logic out_full;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/nas_if.sv]
`default_nettype none
interface nas_in_if;
  logic               valid;
  logic               ready;
  logic               first_of_frame;
  logic        [31:0] cell_density;
  logic        [31:0] cell_volume;
  logic signed [31:0] cell_pressure;
  logic signed [31:0] cell_viscosity;
  logic        [31:0] face_xarea;
  logic        [31:0] face_yarea;
  logic signed [31:0] old_xvel;
  logic signed [31:0] old_yvel;

  modport source (output valid, first_of_frame, cell_density, cell_volume, cell_pressure,
                  cell_viscosity, face_xarea, face_yarea, old_xvel, old_yvel,
                  input ready);
  modport sink (input valid, first_of_frame, cell_density, cell_volume, cell_pressure,
                cell_viscosity, face_xarea, face_yarea, old_xvel, old_yvel,
                output ready);
endinterface

interface nas_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_xvel;
  logic signed [31:0] new_yvel;
  logic        [31:0] step_by_mass;
  logic               mass_was_zero;

  modport source (output valid, new_xvel, new_yvel, step_by_mass, mass_was_zero,
                  input ready);
  modport sink (input valid, new_xvel, new_yvel, step_by_mass, mass_was_zero,
                output ready);
endinterface
`default_nettype wire

[hdl/nas_ctrl.sv]
`default_nettype none
module nas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  input  wire nas_pkg::dp_stat_t stat,
  output nas_pkg::dp_cmd_t       cmd
);

  nas_pkg::state_t  state_r, state_nxt;
  nas_pkg::mul_op_t op_r, op_nxt;
  logic             pass_r, pass_nxt;
  logic [nas_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_free;

  assign out_free = !stat.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nas_pkg::ST_IDLE;
      op_r    <= nas_pkg::OP_MASS;
      pass_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pass_r  <= pass_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pass_nxt  = pass_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      nas_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nas_pkg::ST_MUL;
          op_nxt    = nas_pkg::OP_MASS;
          pass_nxt  = 1'b0;
        end
      end
      nas_pkg::ST_MUL: state_nxt = nas_pkg::ST_WB;
      nas_pkg::ST_WB: begin
        state_nxt = nas_pkg::ST_MUL;
        case (op_r)
          nas_pkg::OP_MASS: state_nxt = nas_pkg::ST_SUM;
          nas_pkg::OP_T1:   op_nxt = nas_pkg::OP_T2;
          nas_pkg::OP_T2:   op_nxt = nas_pkg::OP_T3;
          nas_pkg::OP_T3:   op_nxt = nas_pkg::OP_T4;
          nas_pkg::OP_T4:   op_nxt = nas_pkg::OP_XLO;
          nas_pkg::OP_XLO:  op_nxt = nas_pkg::OP_XHI;
          nas_pkg::OP_XHI:  op_nxt = nas_pkg::OP_YLO;
          nas_pkg::OP_YLO:  op_nxt = nas_pkg::OP_YHI;
          nas_pkg::OP_YHI: begin
            if (pass_r) begin
              state_nxt = nas_pkg::ST_UPD;
            end else begin
              pass_nxt = 1'b1;
              op_nxt   = nas_pkg::OP_T1;
            end
          end
          default: state_nxt = nas_pkg::ST_IDLE;
        endcase
      end
      nas_pkg::ST_SUM: begin
        cnt_nxt   = '0;
        state_nxt = stat.interior ? nas_pkg::ST_DIV : nas_pkg::ST_UPD;
      end
      nas_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == nas_pkg::CNT_W'(nas_pkg::DIV_STEPS - 1)) begin
          state_nxt = nas_pkg::ST_MUL;
          op_nxt    = nas_pkg::OP_T1;
          pass_nxt  = 1'b0;
        end
      end
      nas_pkg::ST_UPD: state_nxt = stat.interior ? nas_pkg::ST_OUT : nas_pkg::ST_IDLE;
      nas_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = nas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == nas_pkg::ST_IDLE);
    cmd          = '0;
    cmd.op       = op_r;
    cmd.pass     = pass_r;
    cmd.accept   = (state_r == nas_pkg::ST_IDLE) && in_valid;
    cmd.mul_go   = (state_r == nas_pkg::ST_MUL);
    cmd.wb       = (state_r == nas_pkg::ST_WB);
    cmd.sum      = (state_r == nas_pkg::ST_SUM);
    cmd.div_step = (state_r == nas_pkg::ST_DIV);
    cmd.upd      = (state_r == nas_pkg::ST_UPD);
    cmd.load_out = (state_r == nas_pkg::ST_OUT) && out_free;
  end

endmodule
`default_nettype wire

[hdl/nas_dp.sv]
`default_nettype none
module nas_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nas_pkg::dp_cmd_t   cmd,
  output nas_pkg::dp_stat_t       stat,
  input  wire logic        [31:0] time_step,
  input  wire logic        [10:0] row_points,
  input  wire logic               first_of_frame,
  input  wire logic        [31:0] cell_density,
  input  wire logic        [31:0] cell_volume,
  input  wire logic signed [31:0] cell_pressure,
  input  wire logic signed [31:0] cell_viscosity,
  input  wire logic        [31:0] face_xarea,
  input  wire logic        [31:0] face_yarea,
  input  wire logic signed [31:0] old_xvel,
  input  wire logic signed [31:0] old_yvel,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed      [31:0] new_xvel,
  output logic signed      [31:0] new_yvel,
  output logic             [31:0] step_by_mass,
  output logic                    mass_was_zero
);

  localparam int AW = nas_pkg::ADDR_W;
  localparam logic [48:0] PROD_CAP = 49'h1_0000_0000_0000;

  // Line buffers for the row above.
  logic [63:0] mass_mem  [nas_pkg::MAX_ROW_POINTS];
  logic [31:0] press_mem [nas_pkg::MAX_ROW_POINTS];
  logic [31:0] visc_mem  [nas_pkg::MAX_ROW_POINTS];
  logic [31:0] xarea_mem [nas_pkg::MAX_ROW_POINTS];
  logic [63:0] rd_mass_r;
  logic [31:0] rd_press_r, rd_visc_r, rd_xarea_r;

  logic [63:0] left_mass_r, ul_mass_r;
  logic [31:0] left_press_r, left_visc_r, left_yarea_r, ul_press_r, ul_visc_r;
  logic [AW-1:0] col_r, c_r, c_w;
  logic pfr_r, pfr_w, pfr_eff_r, interior_r;

  logic [31:0] dens_r, vol_r, p_r, v_r, xa_r, ya_r;
  logic signed [31:0] xv_r, yv_r;
  logic [63:0] mass_r, q_r, rem_r, lo_r;
  logic [31:0] bits_r, quo_r, step_w;
  logic zero_r, sat_r;
  logic [64:0] mul_r;
  logic signed [50:0] gx_r, gy_r;

  logic out_valid_r;
  logic signed [31:0] out_xv_r, out_yv_r;
  logic [31:0] out_step_r;
  logic out_zero_r;

  function automatic logic [31:0] rowlen(input logic [10:0] rp);
    logic [31:0] r;
    r = 32'(rp);
    if (r < 32'(nas_pkg::ROW_MIN)) begin
      r = 32'(nas_pkg::ROW_MIN);
    end
    if (r > 32'(nas_pkg::MAX_ROW_POINTS)) begin
      r = 32'(nas_pkg::MAX_ROW_POINTS);
    end
    return r;
  endfunction

  assign c_w   = first_of_frame ? '0 : col_r;
  assign pfr_w = first_of_frame ? 1'b0 : pfr_r;
  assign step_w = (zero_r || sat_r) ? 32'hFFFF_FFFF : quo_r;

  always_comb begin
    stat.interior = interior_r;
    stat.out_full = out_valid_r;
  end

  // Multiplier operand selection.
  logic signed [31:0] s_w, l_w, u_w, ul_w;
  logic signed [32:0] d_w;
  logic signed [50:0] g_w;
  logic [50:0] gmag_w;
  logic [32:0] ma_w;
  logic [31:0] mb_w;
  logic neg_w;

  always_comb begin
    s_w  = cmd.pass ? $signed(v_r) : $signed(p_r);
    l_w  = cmd.pass ? $signed(left_visc_r) : $signed(left_press_r);
    u_w  = cmd.pass ? $signed(rd_visc_r) : $signed(rd_press_r);
    ul_w = cmd.pass ? $signed(ul_visc_r) : $signed(ul_press_r);
    d_w  = '0;
    mb_w = step_w;
    case (cmd.op)
      nas_pkg::OP_T1: begin
        d_w = 33'(s_w) - 33'(l_w);
        mb_w = xa_r;
      end
      nas_pkg::OP_T2: begin
        d_w = 33'(u_w) - 33'(ul_w);
        mb_w = rd_xarea_r;
      end
      nas_pkg::OP_T3: begin
        d_w = 33'(s_w) - 33'(u_w);
        mb_w = ya_r;
      end
      nas_pkg::OP_T4: begin
        d_w = 33'(l_w) - 33'(ul_w);
        mb_w = left_yarea_r;
      end
      nas_pkg::OP_MASS: mb_w = vol_r;
      default: mb_w = step_w;
    endcase
    g_w = (cmd.op == nas_pkg::OP_XLO || cmd.op == nas_pkg::OP_XHI) ? gx_r : gy_r;
    gmag_w = g_w[50] ? 51'(-g_w) : 51'(g_w);
    case (cmd.op)
      nas_pkg::OP_MASS: begin
        neg_w = 1'b0;
        ma_w  = {1'b0, dens_r};
      end
      nas_pkg::OP_XLO, nas_pkg::OP_YLO: begin
        neg_w = g_w[50];
        ma_w  = {1'b0, gmag_w[31:0]};
      end
      nas_pkg::OP_XHI, nas_pkg::OP_YHI: begin
        neg_w = g_w[50];
        ma_w  = 33'(gmag_w[50:32]);
      end
      default: begin
        neg_w = d_w[32];
        ma_w  = d_w[32] ? 33'(-d_w) : 33'(d_w);
      end
    endcase
  end

  // Write-back arithmetic.
  logic [48:0] tr_w, tcap_w, vr_w, vcap_w;
  logic signed [50:0] term_w, prod_w;
  logic signed [31:0] oldv_w, vel_w;
  logic signed [51:0] diff_w;
  logic [65:0] qsum_w;
  logic [64:0] rem2_w;
  logic ge_w;

  always_comb begin
    tr_w   = mul_r[64:16];
    tcap_w = (tr_w > PROD_CAP) ? PROD_CAP : tr_w;
    term_w = neg_w ? -$signed({2'b00, tcap_w}) : $signed({2'b00, tcap_w});
    vr_w   = 49'({mul_r[31:0], 16'h0000}) + 49'(lo_r[63:16]);
    vcap_w = ((|mul_r[64:32]) || vr_w > PROD_CAP) ? PROD_CAP : vr_w;
    prod_w = neg_w ? -$signed({2'b00, vcap_w}) : $signed({2'b00, vcap_w});
    oldv_w = (cmd.op == nas_pkg::OP_XHI) ? xv_r : yv_r;
    diff_w = 52'(oldv_w) - 52'(prod_w);
    if (diff_w > 52'sd2147483647) begin
      vel_w = 32'sh7FFF_FFFF;
    end else if (diff_w < -52'sd2147483648) begin
      vel_w = 32'sh8000_0000;
    end else begin
      vel_w = diff_w[31:0];
    end
    qsum_w = 66'(mass_r >> 2) + 66'(rd_mass_r >> 2) + 66'(ul_mass_r >> 2)
           + 66'(left_mass_r >> 2)
           + 66'((4'(mass_r[1:0]) + 4'(rd_mass_r[1:0]) + 4'(ul_mass_r[1:0])
                  + 4'(left_mass_r[1:0])) >> 2);
    rem2_w = {rem_r, bits_r[31]};
    ge_w   = rem2_w >= {1'b0, q_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_mass_r  <= mass_mem[c_w];
      rd_press_r <= press_mem[c_w];
      rd_visc_r  <= visc_mem[c_w];
      rd_xarea_r <= xarea_mem[c_w];
    end
    if (cmd.upd) begin
      mass_mem[c_r]  <= mass_r;
      press_mem[c_r] <= p_r;
      visc_mem[c_r]  <= v_r;
      xarea_mem[c_r] <= xa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      pfr_r        <= 1'b0;
      left_mass_r  <= '0;
      left_press_r <= '0;
      left_visc_r  <= '0;
      left_yarea_r <= '0;
      ul_mass_r    <= '0;
      ul_press_r   <= '0;
      ul_visc_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.upd) begin
        ul_mass_r    <= rd_mass_r;
        ul_press_r   <= rd_press_r;
        ul_visc_r    <= rd_visc_r;
        left_mass_r  <= mass_r;
        left_press_r <= p_r;
        left_visc_r  <= v_r;
        left_yarea_r <= ya_r;
        if (32'(c_r) + 32'd1 >= rowlen(row_points)) begin
          col_r <= '0;
          pfr_r <= 1'b1;
        end else begin
          col_r <= c_r + 1'b1;
          pfr_r <= pfr_eff_r;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_r        <= c_w;
      pfr_eff_r  <= pfr_w;
      interior_r <= pfr_w && (c_w != '0);
      dens_r     <= cell_density;
      vol_r      <= cell_volume;
      p_r        <= cell_pressure;
      v_r        <= cell_viscosity;
      xa_r       <= face_xarea;
      ya_r       <= face_yarea;
      xv_r       <= old_xvel;
      yv_r       <= old_yvel;
    end
    if (cmd.mul_go) begin
      mul_r <= ma_w * 65'(mb_w);
    end
    if (cmd.wb) begin
      case (cmd.op)
        nas_pkg::OP_MASS: mass_r <= mul_r[63:0];
        nas_pkg::OP_T1:   gx_r <= term_w;
        nas_pkg::OP_T2:   gx_r <= gx_r + term_w;
        nas_pkg::OP_T3:   gy_r <= term_w;
        nas_pkg::OP_T4:   gy_r <= gy_r + term_w;
        nas_pkg::OP_XLO, nas_pkg::OP_YLO: lo_r <= mul_r[63:0];
        nas_pkg::OP_XHI:  xv_r <= vel_w;
        nas_pkg::OP_YHI:  yv_r <= vel_w;
        default: lo_r <= lo_r;
      endcase
    end
    if (cmd.sum) begin
      q_r    <= qsum_w[63:0];
      zero_r <= (qsum_w[63:0] == 64'd0);
      // The quotient overflows 32 bits exactly when the divisor is not above dt/2.
      sat_r  <= (qsum_w[63:0] <= 64'(time_step[31:1]));
      rem_r  <= 64'(time_step[31:1]);
      bits_r <= {time_step[0], 31'd0};
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge_w ? 64'(rem2_w - {1'b0, q_r}) : rem2_w[63:0];
      quo_r  <= {quo_r[30:0], ge_w};
      bits_r <= {bits_r[30:0], 1'b0};
    end
    if (cmd.load_out) begin
      out_xv_r   <= xv_r;
      out_yv_r   <= yv_r;
      out_step_r <= step_w;
      out_zero_r <= zero_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign new_xvel      = out_xv_r;
  assign new_yvel      = out_yv_r;
  assign step_by_mass  = out_step_r;
  assign mass_was_zero = out_zero_r;

endmodule
`default_nettype wire

[hdl/nodal_acceleration_stencil.sv]
`default_nettype none
// Nodal acceleration stencil for a padded 2D mesh, Q16.16 fixed point.
// Points enter in raster order on in_ch, one transfer per grid point; set
// first_of_frame on the first point of a mesh. Column 0 and the first row
// are padding: they fill the line buffers but give no result. Every other
// point gives one result on out_ch: new velocities, step_by_mass and a flag
// for zero nodal mass.
// Software sets time_step and row_points over the cfg_ APB port while the
// block is idle; reads return the stored values.
// One point at a time is processed. A pad point passes through the mass
// product, the mass sum and the buffer update, then raises in_ready again.
// An interior point runs the mass product, the mass sum, a radix-2 divider
// for dt/(2*mass), the remaining products and the buffer update, then loads
// the output register when free. All 17 products use one 33x32 multiplier.
// The output register holds a result while the receiver stalls, and the
// next point is accepted meanwhile; a second result waits until it drains.
// Reset (synchronous, active low) clears the counters and the neighbour
// registers, zeroes time_step, sets row_points to 2; line buffers are kept.
module nodal_acceleration_stencil (
  input  wire logic        clk,
  input  wire logic        rst_n,
  nas_in_if.sink           in_ch,
  nas_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [31:0] time_step_r;
  logic [10:0] row_points_r;
  nas_pkg::dp_cmd_t  cmd;
  nas_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r  <= '0;
      row_points_r <= 11'd2;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == nas_pkg::REG_TIME_STEP) begin
        time_step_r <= cfg_pwdata;
      end else begin
        row_points_r <= cfg_pwdata[10:0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == nas_pkg::REG_ROW_POINTS) ? {21'd0, row_points_r}
                                                                 : time_step_r;

  nas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nas_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .time_step      (time_step_r),
    .row_points     (row_points_r),
    .first_of_frame (in_ch.first_of_frame),
    .cell_density   (in_ch.cell_density),
    .cell_volume    (in_ch.cell_volume),
    .cell_pressure  (in_ch.cell_pressure),
    .cell_viscosity (in_ch.cell_viscosity),
    .face_xarea     (in_ch.face_xarea),
    .face_yarea     (in_ch.face_yarea),
    .old_xvel       (in_ch.old_xvel),
    .old_yvel       (in_ch.old_yvel),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .new_xvel       (out_ch.new_xvel),
    .new_yvel       (out_ch.new_yvel),
    .step_by_mass   (out_ch.step_by_mass),
    .mass_was_zero  (out_ch.mass_was_zero)
  );

endmodule
`default_nettype wire

[hdl/nas_checker.sv]
`default_nettype none
module nas_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] new_xvel,
  input wire logic [31:0] step_by_mass
);

  // A point is worked on alone, so the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  // A result never appears in the cycle after an input transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(new_xvel) && $stable(step_by_mass)))
    else $error("result changed while stalled");

endmodule

bind nodal_acceleration_stencil nas_checker u_nas_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .new_xvel     (out_ch.new_xvel),
  .step_by_mass (out_ch.step_by_mass)
);
`default_nettype wire
